// File: src/bsr_pkg.sv
package bsr_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int INT_BITS    = 24;
   localparam int MAX_PLACES  = 6;
   localparam int PLACES_BITS = 3;

   localparam int TOTAL_BITS    = INT_BITS + FRAC_BITS;
   localparam int ROOT_BITS     = (INT_BITS + 1) / 2 + 1 + FRAC_BITS;
   localparam int HALF_BITS     = (TOTAL_BITS + 1) / 2;
   localparam int SQ_BITS       = 4 * HALF_BITS;
   localparam int REQ_DATA_BITS = ((TOTAL_BITS + PLACES_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

   localparam logic [TOTAL_BITS-1:0] ONE_VALUE = TOTAL_BITS'(1) << FRAC_BITS;

   localparam longint unsigned SCALE_X2 = 64'd2 << FRAC_BITS;

   localparam logic [TOTAL_BITS-1:0] TOL_P1 = TOTAL_BITS'((SCALE_X2 / 64'd10 + 64'd1) / 64'd2);
   localparam logic [TOTAL_BITS-1:0] TOL_P2 = TOTAL_BITS'((SCALE_X2 / 64'd100 + 64'd1) / 64'd2);
   localparam logic [TOTAL_BITS-1:0] TOL_P3 =
      TOTAL_BITS'((SCALE_X2 / 64'd1000 + 64'd1) / 64'd2);
   localparam logic [TOTAL_BITS-1:0] TOL_P4 =
      TOTAL_BITS'((SCALE_X2 / 64'd10000 + 64'd1) / 64'd2);
   localparam logic [TOTAL_BITS-1:0] TOL_P5 =
      TOTAL_BITS'((SCALE_X2 / 64'd100000 + 64'd1) / 64'd2);
   localparam logic [TOTAL_BITS-1:0] TOL_P6 =
      TOTAL_BITS'((SCALE_X2 / 64'd1000000 + 64'd1) / 64'd2);

   localparam logic [PLACES_BITS-1:0] MAX_PLACES_CODE = PLACES_BITS'(MAX_PLACES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_CMP,
      ST_FINISH
   } bsr_state_type;

   typedef enum logic [1:0] {
      MUL_LL,
      MUL_HL,
      MUL_HH
   } bsr_mul_sel_type;

   typedef enum logic [1:0] {
      ACC_LOAD,
      ACC_ADD_MID,
      ACC_ADD_HIGH
   } bsr_acc_sel_type;

   typedef struct packed {
      logic            load;
      logic            check;
      logic            mul_en;
      bsr_mul_sel_type mul_sel;
      logic            acc_en;
      bsr_acc_sel_type acc_sel;
      logic            update;
      logic            out_load;
   } bsr_cmd_type;

   typedef struct packed {
      logic more;
   } bsr_status_type;

   function automatic logic [PLACES_BITS-1:0] clamp_places(
      input logic [PLACES_BITS-1:0] places
   );
      logic [PLACES_BITS-1:0] result;
      result = places;
      if (places == '0) begin
         result = PLACES_BITS'(1);
      end else if (places > MAX_PLACES_CODE) begin
         result = MAX_PLACES_CODE;
      end
      return result;
   endfunction

   function automatic logic [TOTAL_BITS-1:0] tol_of(input logic [PLACES_BITS-1:0] places);
      logic [TOTAL_BITS-1:0] result;
      case (places)
         3'd1:    result = TOL_P1;
         3'd2:    result = TOL_P2;
         3'd3:    result = TOL_P3;
         3'd4:    result = TOL_P4;
         3'd5:    result = TOL_P5;
         3'd6:    result = TOL_P6;
         default: result = TOL_P6;
      endcase
      return result;
   endfunction

endpackage

// File: src/bsr_ctrl.sv
module bsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bsr_pkg::bsr_status_type status,
   output bsr_pkg::bsr_cmd_type    cmd
);

   bsr_pkg::bsr_state_type state_ff;
   bsr_pkg::bsr_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = bsr_pkg::ST_CHECK;
            end
         end
         bsr_pkg::ST_CHECK: begin
            state_in = status.more ? bsr_pkg::ST_MUL0 : bsr_pkg::ST_FINISH;
         end
         bsr_pkg::ST_MUL0:  state_in = bsr_pkg::ST_MUL1;
         bsr_pkg::ST_MUL1:  state_in = bsr_pkg::ST_MUL2;
         bsr_pkg::ST_MUL2:  state_in = bsr_pkg::ST_MUL3;
         bsr_pkg::ST_MUL3:  state_in = bsr_pkg::ST_CMP;
         bsr_pkg::ST_CMP:   state_in = bsr_pkg::ST_CHECK;
         bsr_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = bsr_pkg::ST_IDLE;
            end
         end
         default: state_in = bsr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.mul_sel   = bsr_pkg::MUL_LL;
      cmd.acc_sel   = bsr_pkg::ACC_LOAD;
      case (state_ff)
         bsr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         bsr_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
         end
         bsr_pkg::ST_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bsr_pkg::MUL_LL;
         end
         bsr_pkg::ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bsr_pkg::MUL_HL;
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = bsr_pkg::ACC_LOAD;
         end
         bsr_pkg::ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bsr_pkg::MUL_HH;
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = bsr_pkg::ACC_ADD_MID;
         end
         bsr_pkg::ST_MUL3: begin
            cmd.acc_en  = 1'b1;
            cmd.acc_sel = bsr_pkg::ACC_ADD_HIGH;
         end
         bsr_pkg::ST_CMP: begin
            cmd.update = 1'b1;
         end
         bsr_pkg::ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // hold the result until the receiver takes it
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/bsr_datapath.sv
module bsr_datapath (
   input  logic                                 clock,
   input  bsr_pkg::bsr_cmd_type                 cmd,
   input  logic [bsr_pkg::REQ_DATA_BITS-1:0]    req_data,
   output bsr_pkg::bsr_status_type              status,
   output logic [bsr_pkg::ROOT_BITS-1:0]        root
);

   localparam int H = bsr_pkg::HALF_BITS;

   logic [bsr_pkg::TOTAL_BITS-1:0]  x_ff;
   logic [bsr_pkg::TOTAL_BITS-1:0]  lo_ff;
   logic [bsr_pkg::TOTAL_BITS-1:0]  hi_ff;
   logic [bsr_pkg::TOTAL_BITS-1:0]  tol_ff;
   logic [bsr_pkg::TOTAL_BITS-1:0]  mid_ff;
   logic [2*H-1:0]                  prod_ff;
   logic [bsr_pkg::SQ_BITS-1:0]     acc_ff;
   logic [bsr_pkg::ROOT_BITS-1:0]   root_ff;

   logic [bsr_pkg::TOTAL_BITS-1:0]  radicand;
   logic [bsr_pkg::PLACES_BITS-1:0] places;
   logic [bsr_pkg::TOTAL_BITS-1:0]  hi_start;
   logic [bsr_pkg::TOTAL_BITS-1:0]  diff;
   logic [bsr_pkg::TOTAL_BITS-1:0]  mid_in;
   logic [2*H-1:0]                  mid_ext;
   logic [H-1:0]                    mid_high;
   logic [H-1:0]                    mid_low;
   logic [H-1:0]                    mul_a;
   logic [H-1:0]                    mul_b;
   logic [2*H-1:0]                  prod_in;
   logic [bsr_pkg::SQ_BITS-1:0]     prod_wide;
   logic [bsr_pkg::SQ_BITS-1:0]     acc_in;
   logic [bsr_pkg::SQ_BITS-1:0]     target;
   logic                            greater;

   assign radicand = req_data[bsr_pkg::TOTAL_BITS-1:0];
   assign places   = req_data[bsr_pkg::TOTAL_BITS +: bsr_pkg::PLACES_BITS];
   assign hi_start = (radicand > bsr_pkg::ONE_VALUE) ? radicand : bsr_pkg::ONE_VALUE;

   assign diff        = hi_ff - lo_ff;
   assign status.more = diff > tol_ff;
   assign mid_in      = lo_ff + (diff >> 1);

   assign mid_ext  = (2*H)'(mid_ff);
   assign mid_high = mid_ext[2*H-1:H];
   assign mid_low  = mid_ext[H-1:0];

   always_comb begin
      case (cmd.mul_sel)
         bsr_pkg::MUL_LL: begin
            mul_a = mid_low;
            mul_b = mid_low;
         end
         bsr_pkg::MUL_HL: begin
            mul_a = mid_high;
            mul_b = mid_low;
         end
         bsr_pkg::MUL_HH: begin
            mul_a = mid_high;
            mul_b = mid_high;
         end
         default: begin
            mul_a = mid_low;
            mul_b = mid_low;
         end
      endcase
   end

   assign prod_in   = (2*H)'(mul_a) * (2*H)'(mul_b);
   assign prod_wide = bsr_pkg::SQ_BITS'(prod_ff);

   always_comb begin
      case (cmd.acc_sel)
         bsr_pkg::ACC_LOAD:     acc_in = prod_wide;
         bsr_pkg::ACC_ADD_MID:  acc_in = acc_ff + (prod_wide << (H + 1));
         bsr_pkg::ACC_ADD_HIGH: acc_in = acc_ff + (prod_wide << (2 * H));
         default:               acc_in = prod_wide;
      endcase
   end

   assign target  = bsr_pkg::SQ_BITS'(x_ff) << bsr_pkg::FRAC_BITS;
   assign greater = acc_ff > target;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= radicand;
         lo_ff  <= '0;
         hi_ff  <= hi_start;
         tol_ff <= bsr_pkg::tol_of(bsr_pkg::clamp_places(places));
      end else if (cmd.update) begin
         if (greater) begin
            hi_ff <= mid_ff;
         end else begin
            lo_ff <= mid_ff;
         end
      end
      if (cmd.check) begin
         mid_ff <= mid_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.out_load) begin
         root_ff <= mid_ff[bsr_pkg::ROOT_BITS-1:0];
      end
   end

   assign root = root_ff;

endmodule

// File: src/bisection_square_root_top.sv
// Square root by bisection on unsigned Q24.24 values.
// Input transfers on the req_ channel carry a radicand and a decimal-place
// count (1 to 6; 0 acts as 1, above 6 acts as 6). The block searches
// [0, max(radicand, 1.0)] until the interval is no wider than 10^-places and
// returns the midpoint on the rsp_ channel, one result per input transfer.
// Each halving steps through CHECK (form the midpoint, test the width),
// MUL0 to MUL2 (the midpoint square through a single 24x24 multiplier as
// three partial products), MUL3 (add the top product) and CMP (compare the
// square with the radicand). After the last width test FINISH waits for a
// free output register; rsp_tvalid rises as the block returns to idle, ready
// for the next input. The number of halvings is about log2(max(radicand,
// 1.0) / tolerance), up to 44 for a full-scale radicand at six places.
// One item is in flight at a time; req_tready is high only while idle.
// The result sits in an output register: a stalled receiver does not block
// the next input, only the hand-over of the following result.
// Synchronous reset returns to idle and drops any pending result.
module bisection_square_root_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // radicand [47:0], decimal_places [50:48], zero fill
   input  logic [bsr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // root [36:0], zero fill
   output logic [bsr_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   bsr_pkg::bsr_cmd_type          cmd;
   bsr_pkg::bsr_status_type       status;
   logic [bsr_pkg::ROOT_BITS-1:0] root;

   bsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bsr_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_tdata),
      .status   (status),
      .root     (root)
   );

   assign rsp_tdata = bsr_pkg::RSP_DATA_BITS'(root);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("input taken while a search is running");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   a_compare_after_square: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.acc_en && cmd.acc_sel == bsr_pkg::ACC_ADD_HIGH))
      else $error("compare without a finished square");

   a_check_follows_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> cmd.check)
      else $error("bound update not followed by width test");

endmodule

// File: tb/sv/tb_bisection_square_root_top.sv
module tb_bisection_square_root_top;

   localparam int TOTAL_ITEMS  = 900;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 800;

   class sqrt_scoreboard;
      logic [bsr_pkg::ROOT_BITS-1:0] expected_roots[$];
      int unsigned                   mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [bsr_pkg::ROOT_BITS-1:0] predict_root(
         logic [bsr_pkg::TOTAL_BITS-1:0] radicand,
         logic [bsr_pkg::PLACES_BITS-1:0] places
      );
         logic [63:0]  lo;
         logic [63:0]  hi;
         logic [63:0]  mid;
         logic [63:0]  tol;
         logic [63:0]  pow10;
         logic [127:0] square;
         logic [127:0] target;
         int unsigned  digits;
         digits = places;
         if (digits < 1) begin
            digits = 1;
         end
         if (digits > bsr_pkg::MAX_PLACES) begin
            digits = bsr_pkg::MAX_PLACES;
         end
         pow10 = 64'd1;
         repeat (digits) pow10 = pow10 * 64'd10;
         tol = (((64'd1 << bsr_pkg::FRAC_BITS) * 64'd2) / pow10 + 64'd1) / 64'd2;
         if (tol == 64'd0) begin
            tol = 64'd1;
         end
         lo = 64'd0;
         hi = (radicand > bsr_pkg::ONE_VALUE) ? 64'(radicand) : 64'(bsr_pkg::ONE_VALUE);
         target = 128'(radicand) << bsr_pkg::FRAC_BITS;
         while (hi - lo > tol) begin
            mid = lo + ((hi - lo) >> 1);
            square = 128'(mid) * 128'(mid);
            if (square > target) begin
               hi = mid;
            end else begin
               lo = mid;
            end
         end
         return bsr_pkg::ROOT_BITS'(lo + ((hi - lo) >> 1));
      endfunction

      function void note_radicand(logic [bsr_pkg::TOTAL_BITS-1:0] radicand,
                                  logic [bsr_pkg::PLACES_BITS-1:0] places);
         expected_roots.push_back(predict_root(radicand, places));
      endfunction

      function void check_root(logic [bsr_pkg::RSP_DATA_BITS-1:0] data);
         logic [bsr_pkg::ROOT_BITS-1:0] want;
         if (expected_roots.size() == 0) begin
            $error("unexpected result transfer: root actual %0h",
                   data[bsr_pkg::ROOT_BITS-1:0]);
            mismatches++;
         end else begin
            want = expected_roots.pop_front();
            if (data[bsr_pkg::ROOT_BITS-1:0] !== want) begin
               $error("root mismatch: expected %0h actual %0h", want,
                      data[bsr_pkg::ROOT_BITS-1:0]);
               mismatches++;
            end
            if (data[bsr_pkg::RSP_DATA_BITS-1:bsr_pkg::ROOT_BITS] !== '0) begin
               $error("rsp_tdata fill mismatch: expected 0 actual %0h",
                      data[bsr_pkg::RSP_DATA_BITS-1:bsr_pkg::ROOT_BITS]);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_roots.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [bsr_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [bsr_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   sqrt_scoreboard sb = new();
   bit             rsp_hold_request = 1'b0;

   bisection_square_root_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_radicand(req_tdata[bsr_pkg::TOTAL_BITS-1:0],
                          req_tdata[bsr_pkg::TOTAL_BITS +: bsr_pkg::PLACES_BITS]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_root(rsp_tdata);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_bisection_square_root_top failed");
      $finish;
   end

   // receiver: stretches of always-ready, light and heavy stalls, one long hold
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 120);
            repeat (span) begin
               case (mode)
                  0: begin
                     rsp_tready <= 1'b1;
                  end
                  1: begin
                     rsp_tready <= ($urandom_range(0, 3) != 0);
                  end
                  default: begin
                     rsp_tready <= ($urandom_range(0, 1) == 0);
                  end
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // hold the transfer until accepted; return at the following falling edge
   task automatic send_radicand(logic [bsr_pkg::TOTAL_BITS-1:0] radicand,
                                logic [bsr_pkg::PLACES_BITS-1:0] places);
      req_tvalid <= 1'b1;
      req_tdata  <= bsr_pkg::REQ_DATA_BITS'({places, radicand});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_radicand();
      logic [bsr_pkg::TOTAL_BITS-1:0] radicand;
      logic [11:0]                    whole;
      int                             kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         radicand = bsr_pkg::TOTAL_BITS'({$urandom, $urandom});
      end else if (kind < 6) begin
         radicand = bsr_pkg::TOTAL_BITS'($urandom) & (bsr_pkg::ONE_VALUE - 1);
      end else if (kind < 8) begin
         radicand = bsr_pkg::TOTAL_BITS'({$urandom, $urandom})
                    >> $urandom_range(0, bsr_pkg::TOTAL_BITS - 1);
      end else if (kind < 9) begin
         whole = 12'($urandom_range(0, 4095));
         radicand = (bsr_pkg::TOTAL_BITS'(whole) * bsr_pkg::TOTAL_BITS'(whole))
                    << bsr_pkg::FRAC_BITS;
      end else begin
         case ($urandom_range(0, 4))
            0: radicand = '0;
            1: radicand = bsr_pkg::ONE_VALUE;
            2: radicand = '1;
            3: radicand = bsr_pkg::ONE_VALUE - bsr_pkg::TOTAL_BITS'($urandom_range(1, 20));
            default: radicand = bsr_pkg::ONE_VALUE
                                + bsr_pkg::TOTAL_BITS'($urandom_range(1, 20));
         endcase
      end
      send_radicand(radicand, bsr_pkg::PLACES_BITS'($urandom_range(0, 7)));
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      int burst_start;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_radicand('0, 3'd1);
      send_radicand('0, 3'd6);
      send_radicand(bsr_pkg::TOTAL_BITS'(1), 3'd3);
      send_radicand(bsr_pkg::ONE_VALUE - 1, 3'd2);
      send_radicand(bsr_pkg::ONE_VALUE, 3'd1);
      send_radicand(bsr_pkg::ONE_VALUE + 1, 3'd4);
      send_radicand(bsr_pkg::ONE_VALUE << 1, 3'd5);
      send_radicand(bsr_pkg::ONE_VALUE << 2, 3'd6);
      send_radicand(bsr_pkg::ONE_VALUE >> 2, 3'd0);
      send_radicand(bsr_pkg::ONE_VALUE >> 1, 3'd7);
      send_radicand('1, 3'd7);
      send_radicand('1, 3'd6);
      send_radicand('1, 3'd1);
      send_radicand('1, 3'd0);
      send_radicand(bsr_pkg::TOTAL_BITS'(144) << bsr_pkg::FRAC_BITS, 3'd3);
      send_radicand(bsr_pkg::TOTAL_BITS'(1) << (bsr_pkg::TOTAL_BITS - 1), 3'd5);
      send_radicand(48'h5555_5555_5555, 3'd2);
      send_radicand(48'hAAAA_AAAA_AAAA, 3'd4);
      send_radicand(bsr_pkg::TOTAL_BITS'(1678), 3'd6);
      send_radicand(bsr_pkg::TOTAL_BITS'(17), 3'd7);
      send_radicand(bsr_pkg::TOTAL_BITS'(4095 * 4095) << bsr_pkg::FRAC_BITS, 3'd6);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);

      sent = 0;
      while (sent < TOTAL_ITEMS) begin
         burst = $urandom_range(1, 24);
         burst_start = sent;
         while (burst > 0 && sent < TOTAL_ITEMS) begin
            send_random_radicand();
            sent++;
            burst--;
            if (sent == TOTAL_ITEMS / 3) begin
               rsp_hold_request = 1'b1;
            end
         end
         if (burst_start < (2 * TOTAL_ITEMS) / 3 && sent >= (2 * TOTAL_ITEMS) / 3) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (sb.pending() != 0);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_bisection_square_root_top passed");
      end else begin
         $display("tb_bisection_square_root_top failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/bsr_pkg.sv
src/bsr_ctrl.sv
src/bsr_datapath.sv
src/bisection_square_root_top.sv
tb/sv/tb_bisection_square_root_top.sv
